>>> design/arcps_pkg.sv
// Shared types, constants and tables for the arc point sampler.
`timescale 1ns / 1ps
package arcps_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_POINTS   = 64;
  localparam int CNT_W        = 7;
  localparam int IDX_W        = 6;
  localparam int T_W          = FRAC_BITS + 1;
  localparam int CORDIC_STEPS = 31;
  localparam int STEP_W       = 5;
  localparam int CORD_W       = 64;
  // Divider: for arcs the numerator holds sweep * t numerator, the divisor one * (n - 1).
  localparam int DEN_W        = FRAC_BITS + IDX_W;
  localparam int NUM_W        = 32 + DEN_W;
  localparam int DCNT_W       = $clog2(NUM_W);
  localparam int LPROD_W      = 33 + IDX_W;

  localparam logic [29:0] GAIN_COMP    = 30'd652032875;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [T_W-1:0] T_ONE     = T_W'(1) << FRAC_BITS;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEGIN_X  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEGIN_Y  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FINISH_X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FINISH_Y = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 4'd7;

  localparam logic [1:0] MODE_CCW  = 2'd0;
  localparam logic [1:0] MODE_CW   = 2'd1;
  localparam logic [1:0] MODE_LINE = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] point_count;
    logic [T_W-1:0]   t_from;
    logic [T_W-1:0]   t_to;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [IDX_W-1:0]   point_index;
    logic               last_point;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [T_W-1:0]   ta;
    logic [T_W-1:0]   tb;
  } job_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] begin_x;
    logic signed [31:0] begin_y;
    logic signed [31:0] finish_x;
    logic signed [31:0] finish_y;
    logic [30:0]        arc_radius;
    logic [1:0]         arc_mode;
  } cfg_t;

  function automatic logic [31:0] atan_at(input logic [STEP_W-1:0] s);
    logic [31:0] v;
    case (s)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/arcps_front.sv
// Request intake: clamps the fields, drops empty requests, feeds the job queue.
`timescale 1ns / 1ps
module arcps_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  arcps_pkg::in_item_t in_data,
  input  logic                q_full,
  output logic                q_push,
  output arcps_pkg::job_t     q_job
);

  logic [arcps_pkg::CNT_W-1:0] n_sat;

  always_comb begin
    if (in_data.point_count > arcps_pkg::CNT_W'(arcps_pkg::MAX_POINTS)) begin
      n_sat = arcps_pkg::CNT_W'(arcps_pkg::MAX_POINTS);
    end else begin
      n_sat = in_data.point_count;
    end
  end

  assign in_stall = q_full;
  // drop a request with no points: accept it, queue nothing
  assign q_push   = in_valid && !q_full && (in_data.point_count != '0);

  assign q_job.n  = n_sat;
  assign q_job.ta = (in_data.t_from > arcps_pkg::T_ONE) ? arcps_pkg::T_ONE : in_data.t_from;
  assign q_job.tb = (in_data.t_to > arcps_pkg::T_ONE) ? arcps_pkg::T_ONE : in_data.t_to;

endmodule

>>> design/arcps_queue.sv
// Two-entry job queue between intake and the point engine.
`timescale 1ns / 1ps
module arcps_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  arcps_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output arcps_pkg::job_t head_job
);

  arcps_pkg::job_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign avail    = (cnt_r != 2'd0);
  assign head_job = mem_r[rp_r];
  assign do_pop   = pop && avail;

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule

>>> design/arcps_back.sv
// Point engine: CORDIC vectoring and rotation, bit-serial divider, output register.
`timescale 1ns / 1ps
module arcps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  arcps_pkg::cfg_t      cfg,
  input  logic                 q_avail,
  input  arcps_pkg::job_t      q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output arcps_pkg::out_item_t out_data
);

  localparam int IW = arcps_pkg::IDX_W;
  localparam int NW = arcps_pkg::NUM_W;
  localparam int DW = arcps_pkg::DEN_W;
  localparam int TW = arcps_pkg::T_W;
  localparam int LW = arcps_pkg::LPROD_W;
  localparam int CW = arcps_pkg::CORD_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_VLOAD = 4'd1;
  localparam logic [3:0] S_VEC   = 4'd2;
  localparam logic [3:0] S_TN    = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_RLOAD = 4'd6;
  localparam logic [3:0] S_ROT   = 4'd7;
  localparam logic [3:0] S_RFIN  = 4'd8;
  localparam logic [3:0] S_LLOAD = 4'd9;
  localparam logic [3:0] S_LFIN  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_r;
  logic [arcps_pkg::CNT_W-1:0] n_r;
  logic [IW-1:0] d_r, i_r;
  logic [TW-1:0] ta_r, tb_r;
  logic pass_r, neg_r, is_line_r;
  logic [31:0] a0_r, a1_r, base_r;
  logic signed [CW-1:0] x_r, y_r;
  logic [31:0] z_r;
  logic [arcps_pkg::STEP_W-1:0] step_r;
  logic [DW-1:0] tnum_r, den_r, rem_r;
  logic [NW-1:0] num_r, quo_r;
  logic [arcps_pkg::DCNT_W-1:0] dcnt_r;
  logic signed [31:0] res_x_r, res_y_r;
  logic out_valid_r;
  arcps_pkg::out_item_t out_data_r;

  // CORDIC micro-rotation shared by vectoring and rotation
  logic vec_mode, rot_dir;
  logic signed [CW-1:0] xs, ys, x_step, y_step;
  logic [31:0] z_step, atan_v;

  assign vec_mode = (state_r == S_VEC);
  assign xs       = x_r >>> step_r;
  assign ys       = y_r >>> step_r;
  assign atan_v   = arcps_pkg::atan_at(step_r);
  assign rot_dir  = vec_mode ? !(y_r > 0) : !z_r[31];

  always_comb begin
    if (rot_dir) begin
      x_step = x_r - ys;
      y_step = y_r + xs;
      z_step = z_r - atan_v;
    end else begin
      x_step = x_r + ys;
      y_step = y_r - xs;
      z_step = z_r + atan_v;
    end
  end

  // vectoring setup
  logic signed [31:0] vp_x, vp_y;
  logic signed [32:0] vdx, vdy;
  logic signed [33:0] vdx34, vdy34, vax, vay;
  logic v_zero, v_neg;

  assign vp_x   = pass_r ? cfg.finish_x : cfg.begin_x;
  assign vp_y   = pass_r ? cfg.finish_y : cfg.begin_y;
  assign vdx    = {vp_x[31], vp_x} - {cfg.center_x[31], cfg.center_x};
  assign vdy    = {vp_y[31], vp_y} - {cfg.center_y[31], cfg.center_y};
  assign v_zero = (vdx == '0) && (vdy == '0);
  assign v_neg  = vdx[32];
  assign vdx34  = {vdx[32], vdx};
  assign vdy34  = {vdy[32], vdy};
  assign vax    = v_neg ? -vdx34 : vdx34;
  assign vay    = v_neg ? -vdy34 : vdy34;

  logic [31:0] vang;
  assign vang = base_r + z_step;

  // sweep offset numerator
  logic [31:0] sweep;
  logic [TW+IW:0] tn_full;
  logic [NW-1:0] sw_prod;
  assign sweep   = a1_r - a0_r;
  assign tn_full = (TW+IW+1)'(ta_r) * (TW+IW+1)'(d_r - i_r)
                 + (TW+IW+1)'(tb_r) * (TW+IW+1)'(i_r);
  assign sw_prod = NW'(sweep) * NW'(tnum_r);

  // divider step
  logic [DW:0] dsh;
  logic dge;
  assign dsh = {rem_r, num_r[NW-1]};
  assign dge = (dsh >= {1'b0, den_r});

  // rotation setup
  logic [31:0] rang;
  logic [60:0] rgain;
  logic rquad;
  assign rang  = a0_r + quo_r[31:0];
  assign rgain = 61'(cfg.arc_radius) * 61'(arcps_pkg::GAIN_COMP);
  assign rquad = ((rang + arcps_pkg::QUARTER_TURN) >= arcps_pkg::HALF_TURN);

  // rotation result, rounded and saturated
  logic signed [CW-1:0] xr, yr;
  logic signed [34:0] sx, sy;
  logic signed [31:0] px_sat, py_sat;
  assign xr = x_r + (CW'(1) <<< 29);
  assign yr = y_r + (CW'(1) <<< 29);
  assign sx = 35'(cfg.center_x) + 35'(signed'(xr[CW-1:30]));
  assign sy = 35'(cfg.center_y) + 35'(signed'(yr[CW-1:30]));

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign px_sat = sat32(sx);
  assign py_sat = sat32(sy);

  // line interpolation
  logic signed [32:0] ldiff;
  logic signed [LW-1:0] lprod, lmag;
  logic signed [31:0] lbase, lval;
  assign ldiff = pass_r ? ({cfg.finish_y[31], cfg.finish_y} - {cfg.begin_y[31], cfg.begin_y})
                        : ({cfg.finish_x[31], cfg.finish_x} - {cfg.begin_x[31], cfg.begin_x});
  assign lprod = $signed({{IW{ldiff[32]}}, ldiff}) * $signed({33'd0, i_r});
  assign lmag  = lprod[LW-1] ? -lprod : lprod;
  assign lbase = pass_r ? cfg.begin_y : cfg.begin_x;
  assign lval  = neg_r ? (lbase - signed'(quo_r[31:0])) : (lbase + signed'(quo_r[31:0]));

  logic out_free, is_last;
  assign out_free = !out_valid_r || !out_stall;
  assign is_last  = ({1'b0, i_r} == (n_r - 1'b1));
  assign q_pop    = (state_r == S_IDLE) && q_avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // S_OUT reloads the output register on its own
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_avail) begin
            n_r       <= q_job.n;
            d_r       <= (q_job.n > 7'd1) ? IW'(q_job.n - 7'd1) : IW'(1);
            i_r       <= '0;
            pass_r    <= 1'b0;
            is_line_r <= (cfg.arc_mode == arcps_pkg::MODE_LINE);
            if (cfg.arc_mode == arcps_pkg::MODE_CW) begin
              ta_r <= q_job.tb;
              tb_r <= q_job.ta;
            end else begin
              ta_r <= q_job.ta;
              tb_r <= q_job.tb;
            end
            if (cfg.arc_mode == arcps_pkg::MODE_LINE) begin
              state_r <= S_LLOAD;
            end else begin
              a0_r    <= '0;
              a1_r    <= '0;
              state_r <= S_VLOAD;
            end
          end
        end
        S_VLOAD: begin
          if (v_zero) begin
            // point at the center: angle zero, no iterations
            if (!pass_r) begin
              a0_r    <= '0;
              pass_r  <= 1'b1;
            end else begin
              if (cfg.arc_mode == arcps_pkg::MODE_CW) begin
                a0_r <= '0;
                a1_r <= a0_r;
              end else begin
                a1_r <= '0;
              end
              state_r <= S_TN;
            end
          end else begin
            x_r     <= {{6{vax[33]}}, vax, 24'd0};
            y_r     <= {{6{vay[33]}}, vay, 24'd0};
            z_r     <= '0;
            base_r  <= v_neg ? arcps_pkg::HALF_TURN : 32'd0;
            step_r  <= '0;
            state_r <= S_VEC;
          end
        end
        S_VEC: begin
          x_r    <= x_step;
          y_r    <= y_step;
          z_r    <= z_step;
          step_r <= step_r + 1'b1;
          if (step_r == arcps_pkg::STEP_W'(arcps_pkg::CORDIC_STEPS - 1)) begin
            if (!pass_r) begin
              a0_r    <= vang;
              pass_r  <= 1'b1;
              state_r <= S_VLOAD;
            end else begin
              // clockwise: swap the two angles
              if (cfg.arc_mode == arcps_pkg::MODE_CW) begin
                a0_r <= vang;
                a1_r <= a0_r;
              end else begin
                a1_r <= vang;
              end
              state_r <= S_TN;
            end
          end
        end
        S_TN: begin
          tnum_r  <= tn_full[DW-1:0];
          state_r <= S_MUL;
        end
        S_MUL: begin
          num_r   <= sw_prod;
          den_r   <= DW'(d_r) << arcps_pkg::FRAC_BITS;
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          num_r  <= num_r << 1;
          quo_r  <= {quo_r[NW-2:0], dge};
          rem_r  <= dge ? DW'(dsh - {1'b0, den_r}) : dsh[DW-1:0];
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == arcps_pkg::DCNT_W'(NW - 1)) begin
            state_r <= is_line_r ? S_LFIN : S_RLOAD;
          end
        end
        S_RLOAD: begin
          // left half-plane: flip x and take a half turn off the angle
          x_r     <= rquad ? -signed'(CW'(rgain)) : signed'(CW'(rgain));
          y_r     <= '0;
          z_r     <= rquad ? (rang - arcps_pkg::HALF_TURN) : rang;
          step_r  <= '0;
          state_r <= S_ROT;
        end
        S_ROT: begin
          x_r    <= x_step;
          y_r    <= y_step;
          z_r    <= z_step;
          step_r <= step_r + 1'b1;
          if (step_r == arcps_pkg::STEP_W'(arcps_pkg::CORDIC_STEPS - 1)) begin
            state_r <= S_RFIN;
          end
        end
        S_RFIN: begin
          res_x_r <= px_sat;
          res_y_r <= py_sat;
          state_r <= S_OUT;
        end
        S_LLOAD: begin
          neg_r   <= lprod[LW-1];
          num_r   <= NW'(lmag) + NW'(d_r >> 1);
          den_r   <= DW'(d_r);
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_LFIN: begin
          if (!pass_r) begin
            res_x_r <= lval;
            pass_r  <= 1'b1;
            state_r <= S_LLOAD;
          end else begin
            res_y_r <= lval;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.point_x     <= res_x_r;
            out_data_r.point_y     <= res_y_r;
            out_data_r.point_index <= i_r;
            out_data_r.last_point  <= is_last;
            i_r                    <= i_r + 1'b1;
            pass_r                 <= 1'b0;
            if (is_last) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= is_line_r ? S_LLOAD : S_TN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/arc_point_sampler_unit.sv
// Top level of the arc point sampler: register bank, intake, job queue, point engine.
//
// Each request emits point_count points (saturated to 64, none for a count of zero)
// evenly spaced along the configured arc or line. Arc requests start with two CORDIC
// vectoring passes; each arc point then takes the 54-step bit-serial divider and the
// 31-step CORDIC rotation, run one after the other. A line point takes two divider
// runs. Two requests can wait in the queue while one is worked on; registers may be
// written only while the block is idle.
`timescale 1ns / 1ps
module arc_point_sampler_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  arcps_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output arcps_pkg::out_item_t                 out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [arcps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                          cfg_data
);

  arcps_pkg::cfg_t cfg_r;
  arcps_pkg::job_t push_job, head_job;
  logic q_full, q_push, q_avail, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      // unknown indexes are dropped
      unique case (cfg_index)
        arcps_pkg::REG_CENTER_X: cfg_r.center_x   <= cfg_data;
        arcps_pkg::REG_CENTER_Y: cfg_r.center_y   <= cfg_data;
        arcps_pkg::REG_BEGIN_X:  cfg_r.begin_x    <= cfg_data;
        arcps_pkg::REG_BEGIN_Y:  cfg_r.begin_y    <= cfg_data;
        arcps_pkg::REG_FINISH_X: cfg_r.finish_x   <= cfg_data;
        arcps_pkg::REG_FINISH_Y: cfg_r.finish_y   <= cfg_data;
        arcps_pkg::REG_RADIUS:   cfg_r.arc_radius <= cfg_data[30:0];
        arcps_pkg::REG_MODE:     cfg_r.arc_mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  arcps_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  arcps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head_job (head_job)
  );

  arcps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_avail   (q_avail),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> tb/sv/arc_point_sampler_unit_tb.sv
// Self-checking testbench for the arc point sampler: random arcs, lines and request windows.
`timescale 1ns / 1ps
module arc_point_sampler_unit_tb;
  import arcps_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int RANDOM_ITEMS = 200;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_MODE + 1'b1;
  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  arc_point_sampler_unit dut (.*);

  always #5 clk = ~clk;

  // shadow of the register bank
  longint cx, cy, bx, by, fx, fy, radius;
  logic [1:0] mode;

  in_item_t  pending_requests[$];
  out_item_t expected_points[$];
  int errors = 0;
  int items_sent = 0;
  bit in_took = 1'b0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  function automatic logic [31:0] vector_angle(longint dx, longint dy);
    longint x, y, xs, ys;
    logic [31:0] z, base;
    z = '0;
    base = '0;
    if (dx == 0 && dy == 0) return 32'd0;
    if (dx < 0) begin
      dx = -dx;
      dy = -dy;
      base = HALF_TURN;
    end
    x = dx * 64'sd16777216;
    y = dy * 64'sd16777216;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end
    end
    return base + z;
  endfunction

  task automatic rotate_radius(input logic [31:0] angle, input longint r,
                               output longint ox, output longint oy);
    longint x, y, xs, ys;
    logic [31:0] z;
    x = r * 64'sd652032875;
    y = 0;
    z = angle;
    if (32'(angle + QUARTER_TURN) >= HALF_TURN) begin
      x = -x;
      z = angle - HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z < HALF_TURN) begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end else begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end
    end
    ox = (x + (64'sd1 <<< 29)) >>> 30;
    oy = (y + (64'sd1 <<< 29)) >>> 30;
  endtask

  function automatic longint div_nearest(longint num, longint den);
    longint unsigned m, q;
    m = (num < 0) ? longint'(-num) : num;
    q = (m + longint'(den) / 2) / longint'(den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Push the points one request should produce.
  task automatic predict_points(input in_item_t req);
    longint unsigned n, ta, tb, d, tnum, tt;
    logic [31:0] a0, a1, sweep, off, ts;
    longint px, py, rx, ry;
    out_item_t pt;
    n = req.point_count;
    ta = req.t_from;
    tb = req.t_to;
    a0 = '0;
    a1 = '0;
    if (n > MAX_POINTS) n = MAX_POINTS;
    if (n == 0) return;
    if (ta > ONE) ta = ONE;
    if (tb > ONE) tb = ONE;
    d = (n > 1) ? n - 1 : 1;
    if (mode != MODE_LINE) begin
      a0 = vector_angle(bx - cx, by - cy);
      a1 = vector_angle(fx - cx, fy - cy);
      if (mode == MODE_CW) begin
        ts = a0; a0 = a1; a1 = ts;
        tt = ta; ta = tb; tb = tt;
      end
    end
    sweep = a1 - a0;
    for (longint unsigned i = 0; i < n; i++) begin
      if (mode == MODE_LINE) begin
        px = bx + div_nearest((fx - bx) * longint'(i), longint'(d));
        py = by + div_nearest((fy - by) * longint'(i), longint'(d));
      end else begin
        tnum = ta * (d - i) + tb * i;
        off = 32'((64'(sweep) * tnum) / (ONE * d));
        rotate_radius(a0 + off, radius, rx, ry);
        px = sat32(cx + rx);
        py = sat32(cy + ry);
      end
      pt.point_x = px[31:0];
      pt.point_y = py[31:0];
      pt.point_index = i[IDX_W-1:0];
      pt.last_point = (i == n - 1);
      expected_points.push_back(pt);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // sender: bursts of random length separated by random gaps
  int gap_left = 0;
  int burst_left = 4;
  always @(negedge clk) begin
    logic next_valid;
    in_item_t next_data;
    next_valid = in_valid;
    next_data = in_data;
    if (in_took) begin
      void'(pending_requests.pop_front());
      next_valid = 1'b0;
    end
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        next_valid = 1'b0;
      end else if (pending_requests.size() > 0) begin
        next_valid = 1'b1;
        next_data = pending_requests[0];
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
    in_took = 1'b0;
    in_valid <= next_valid;
    in_data <= next_data;
  end

  // receiver: stall pattern changes per segment, plus one long hold-off
  int seg_left = 0;
  int stall_pct = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 300);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 40;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: predict on accepted requests, check accepted points
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X: cx = longint'(signed'(cfg_data));
          REG_CENTER_Y: cy = longint'(signed'(cfg_data));
          REG_BEGIN_X:  bx = longint'(signed'(cfg_data));
          REG_BEGIN_Y:  by = longint'(signed'(cfg_data));
          REG_FINISH_X: fx = longint'(signed'(cfg_data));
          REG_FINISH_Y: fy = longint'(signed'(cfg_data));
          REG_RADIUS:   radius = longint'(cfg_data[30:0]);
          REG_MODE:     mode = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        predict_points(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("unexpected point at %0t: index %0d", $time, out_data.point_index);
          errors++;
        end else begin
          want = expected_points.pop_front();
          if (out_data.point_x !== want.point_x)
            report_mismatch("point_x", out_data.point_x, want.point_x);
          if (out_data.point_y !== want.point_y)
            report_mismatch("point_y", out_data.point_y, want.point_y);
          if (out_data.point_index !== want.point_index)
            report_mismatch("point_index", out_data.point_index, want.point_index);
          if (out_data.last_point !== want.last_point)
            report_mismatch("last_point", out_data.last_point, want.last_point);
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_arc(input logic [31:0] ccx, ccy, bbx, bby, ffx, ffy, rr,
                           input logic [1:0] mm);
    write_reg(REG_CENTER_X, ccx);
    write_reg(REG_CENTER_Y, ccy);
    write_reg(REG_BEGIN_X, bbx);
    write_reg(REG_BEGIN_Y, bby);
    write_reg(REG_FINISH_X, ffx);
    write_reg(REG_FINISH_Y, ffy);
    write_reg(REG_RADIUS, rr);
    write_reg(REG_MODE, 32'(mm));
  endtask

  task automatic send(input int cnt, input int tf, input int tt);
    in_item_t it;
    it.point_count = cnt[CNT_W-1:0];
    it.t_from = tf[T_W-1:0];
    it.t_to = tt[T_W-1:0];
    pending_requests.push_back(it);
    items_sent++;
  endtask

  function automatic int rand_count();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(1, 8);
    if (k < 90) return $urandom_range(9, 24);
    if (k < 96) return $urandom_range(64, 127);
    return 0;
  endfunction

  function automatic int rand_t();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 131071);
    return $urandom_range(0, 65536);
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
  endfunction

  task automatic drain();
    wait (pending_requests.size() == 0 && !in_valid && expected_points.size() == 0);
    repeat (300) @(negedge clk);
  endtask

  initial begin
    cx = 0; cy = 0; bx = 0; by = 0; fx = 0; fy = 0; radius = 0; mode = MODE_CCW;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: every point lands on the center
    send(3, 0, 65536);
    send(0, 0, 0);
    drain();

    // quarter circle, unit radius
    write_arc(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, MODE_CCW);
    send(1, 0, 65536);
    send(2, 0, 65536);
    send(5, 65536, 0);
    send(64, 0, 65536);
    send(127, 100, 131071);
    send(100, 131071, 65537);
    send(0, 5, 6);
    drain();

    write_reg(REG_MODE, 32'(MODE_CW));
    send(4, 0, 65536);
    send(3, 16384, 49152);
    drain();

    // line between extreme points
    write_arc(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, MODE_LINE);
    send(2, 0, 65536);
    send(7, 3, 9);
    send(1, 65536, 0);
    drain();

    // saturating arc, begin point at the center, spare mode
    write_arc(32'h7fff_0000, 32'h8000_1000, 32'h7fff_0000, 32'h8000_1000,
              32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, MODE_SPARE);
    write_reg(REG_FIRST_UNUSED + 4'($urandom_range(0, 7)), $urandom);
    send(6, 0, 65536);
    send(3, 65536, 65536);
    drain();

    // long receiver hold-off while requests keep coming
    write_arc(32'h0002_0000, 32'hfffe_0000, 32'h0005_0000, 32'hfffe_0000,
              32'hfff0_0000, 32'hfffd_0000, 32'h0003_0000, MODE_CCW);
    hold_req = 1'b1;
    for (int k = 0; k < 6; k++) send(4, rand_t(), rand_t());
    drain();

    while (items_sent < RANDOM_ITEMS + 25) begin
      write_arc(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50 << 16),
                2'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_FIRST_UNUSED + 4'($urandom_range(0, 7)), $urandom);
      repeat ($urandom_range(10, 30)) send(rand_count(), rand_t(), rand_t());
      drain();
    end

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
